[hdl/tcfsd_pkg.sv]
package tcfsd_pkg;

	// Stamp field width of the request and response items.
	localparam int ITEM_STAMP_W = 16;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_ANY    = 2'd1,
		OP_CLASS0 = 2'd2,
		OP_CLASS1 = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_NONE = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		op_t                     operation;
		logic                    entry_class;
		logic [ITEM_STAMP_W-1:0] entry_stamp;
	} req_item_t;

	typedef struct packed {
		status_t                 status;
		logic                    removed_class;
		logic [ITEM_STAMP_W-1:0] removed_stamp;
	} rsp_item_t;

	typedef enum logic [0:0] {
		CS_IDLE = 1'b0,
		CS_EXEC = 1'b1
	} ctl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // capture a new request, restart the scan
		logic advance;  // move the scan to the next cell
		logic commit;   // perform the request and write the response
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_append;
		logic scan_done;
		logic cur_match;
		logic rsp_free;
	} dp_sts_t;

endpackage

[hdl/tcfsd_ctrl.sv]
module tcfsd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  tcfsd_pkg::dp_sts_t sts,
	output tcfsd_pkg::dp_cmd_t cmd
);
	import tcfsd_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		req_stall   = 1'b1;
		unique case (state_q)
			CS_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = CS_EXEC;
				end
			end
			CS_EXEC: begin
				// The request finishes only once the response register can take its result.
				if (sts.rsp_free) begin
					if (sts.is_append || sts.scan_done || sts.cur_match) begin
						cmd.commit = 1'b1;
						state_d    = CS_IDLE;
					end else begin
						cmd.advance = 1'b1;
					end
				end
			end
			default: state_d = CS_IDLE;
		endcase
	end

endmodule

[hdl/tcfsd_datapath.sv]
module tcfsd_datapath #(
	parameter int DEPTH       = 16,
	parameter int STAMP_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tcfsd_pkg::req_item_t req,
	input  tcfsd_pkg::dp_cmd_t   cmd,
	output tcfsd_pkg::dp_sts_t   sts,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output tcfsd_pkg::rsp_item_t rsp
);
	import tcfsd_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	// Entry cells, head at index zero.
	logic                   cls_q   [DEPTH];
	logic [STAMP_WIDTH-1:0] stamp_q [DEPTH];
	logic [CW-1:0]          occ_q;

	// Request being worked on.
	op_t                    op_q;
	logic                   ecls_q;
	logic [STAMP_WIDTH-1:0] estamp_q;
	logic [CW-1:0]          scan_q;

	logic                   rsp_valid_q;
	rsp_item_t              rsp_q;

	logic                   full;
	logic                   cur_cls;
	logic [STAMP_WIDTH-1:0] cur_stamp;
	logic                   take;
	logic                   put;
	logic [IW-1:0]          scan_idx;
	logic [IW-1:0]          tail_idx;

	assign full      = (occ_q == FULL_COUNT);
	assign scan_idx  = scan_q[IW-1:0];
	assign tail_idx  = occ_q[IW-1:0];
	assign cur_cls   = cls_q[scan_idx];
	assign cur_stamp = stamp_q[scan_idx];

	assign sts.is_append = (op_q == OP_APPEND);
	assign sts.scan_done = (scan_q >= occ_q);
	assign sts.cur_match = (op_q == OP_ANY) || (cur_cls == (op_q == OP_CLASS1));
	assign sts.rsp_free  = !rsp_valid_q || !rsp_stall;

	assign put  = cmd.commit && sts.is_append && !full;
	assign take = cmd.commit && !sts.is_append && !sts.scan_done;

	// Control state: entry count and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (put) begin
				occ_q <= occ_q + CW'(1);
			end else if (take) begin
				occ_q <= occ_q - CW'(1);
			end
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Request capture and scan position.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= req.operation;
			ecls_q   <= req.entry_class;
			estamp_q <= STAMP_WIDTH'(req.entry_stamp);
			scan_q   <= '0;
		end else if (cmd.advance) begin
			scan_q <= scan_q + CW'(1);
		end
	end

	// Cells: an append writes the tail, a removal closes the gap behind the hit.
	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			if (put && (tail_idx == IW'(i))) begin
				cls_q[i]   <= ecls_q;
				stamp_q[i] <= estamp_q;
			end else if (take && (i < DEPTH - 1) && (scan_q <= CW'(i))) begin
				cls_q[i]   <= cls_q[(i < DEPTH - 1) ? i + 1 : i];
				stamp_q[i] <= stamp_q[(i < DEPTH - 1) ? i + 1 : i];
			end
		end
	end

	// Response payload.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			priority if (sts.is_append) begin
				rsp_q.status        <= full ? ST_FULL : ST_OK;
				rsp_q.removed_class <= 1'b0;
				rsp_q.removed_stamp <= '0;
			end else if (sts.scan_done) begin
				rsp_q.status        <= ST_NONE;
				rsp_q.removed_class <= 1'b0;
				rsp_q.removed_stamp <= '0;
			end else begin
				rsp_q.status        <= ST_OK;
				rsp_q.removed_class <= cur_cls;
				rsp_q.removed_stamp <= ITEM_STAMP_W'(cur_stamp);
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[hdl/two_class_fifo_selective_dequeue_unit.sv]
// Sequence: a request is captured, a removal then scans from the head past non-matching
// entries, and the request commits once the response register is free; an append never scans.
// Throughput: one request at a time; the next one is accepted the cycle after the previous
// one finishes, while its response may still wait in the output register.
// Reset: arst_n clears the entry count, the controller and the response valid at once.
module two_class_fifo_selective_dequeue_unit #(
	parameter int DEPTH       = 16,
	parameter int STAMP_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  tcfsd_pkg::req_item_t req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output tcfsd_pkg::rsp_item_t rsp
);
	import tcfsd_pkg::*;

	// The queue is a row of register cells with the oldest entry at the head. A removal
	// walks the cells from the head one per cycle while the response register is free, until
	// it finds an entry of the wanted class or passes the last one; the cells behind the hit
	// then all move one place toward the head at once, so the rest keep their arrival order.

	dp_cmd_t cmd;
	dp_sts_t sts;

	// The controller sequences each request: capture, scan, and commit once the response
	// register is free.
	tcfsd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the cells, the entry count, the scan pointer and the response item.
	tcfsd_datapath #(
		.DEPTH       (DEPTH),
		.STAMP_WIDTH (STAMP_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

[tb/tcfsd_checker.sv]
`timescale 1ns / 1ps

// Watches both channels of the two-class queue, keeps its own copy of the
// queue contents, and compares every accepted response with the one
// predicted for the oldest outstanding request.
module tcfsd_response_checker #(
	parameter int DEPTH       = 16,
	parameter int STAMP_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic                 req_stall,
	input  tcfsd_pkg::req_item_t req,
	input  logic                 rsp_valid,
	input  logic                 rsp_stall,
	input  tcfsd_pkg::rsp_item_t rsp,
	output int                   mismatch_count,
	output int                   awaiting_count
);

	import tcfsd_pkg::*;

	localparam logic [ITEM_STAMP_W-1:0] STAMP_MASK =
		ITEM_STAMP_W'((64'd1 << STAMP_WIDTH) - 64'd1);

	logic                    held_class [DEPTH];
	logic [ITEM_STAMP_W-1:0] held_stamp [DEPTH];
	int                      held_count;
	rsp_item_t               expected_rsp_q [$];

	// Applies one request to the shadow queue and returns its response.
	// A removal from the middle closes the gap, keeping arrival order.
	function automatic rsp_item_t serve_request(req_item_t r);
		rsp_item_t res;
		int        hit;
		res.status        = ST_NONE;
		res.removed_class = 1'b0;
		res.removed_stamp = '0;
		hit               = -1;
		if (r.operation == OP_APPEND) begin
			if (held_count >= DEPTH) begin
				res.status = ST_FULL;
			end else begin
				held_class[held_count] = r.entry_class;
				held_stamp[held_count] = r.entry_stamp & STAMP_MASK;
				held_count++;
				res.status = ST_OK;
			end
		end else begin
			for (int i = 0; i < held_count; i++) begin
				if (hit < 0 && (r.operation == OP_ANY ||
						held_class[i] == (r.operation == OP_CLASS1))) begin
					hit = i;
				end
			end
			if (hit >= 0) begin
				res.status        = ST_OK;
				res.removed_class = held_class[hit];
				res.removed_stamp = held_stamp[hit];
				for (int i = hit; i < held_count - 1; i++) begin
					held_class[i] = held_class[i + 1];
					held_stamp[i] = held_stamp[i + 1];
				end
				held_count--;
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_item_t want;
		if (!arst_n) begin
			held_count     = 0;
			mismatch_count = 0;
			expected_rsp_q.delete();
		end else begin
			// A response always belongs to an earlier request, so it is
			// matched before a request accepted at the same edge is queued.
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp_q.size() == 0) begin
					$display("%0t: unexpected response, expected none actual %h",
						$time, rsp);
					mismatch_count++;
				end else begin
					want = expected_rsp_q.pop_front();
					if (rsp.status !== want.status) begin
						$display("%0t: status mismatch, expected %0h actual %0h",
							$time, want.status, rsp.status);
						mismatch_count++;
					end
					if (rsp.removed_class !== want.removed_class) begin
						$display("%0t: removed_class mismatch, expected %0h actual %0h",
							$time, want.removed_class, rsp.removed_class);
						mismatch_count++;
					end
					if (rsp.removed_stamp !== want.removed_stamp) begin
						$display("%0t: removed_stamp mismatch, expected %h actual %h",
							$time, want.removed_stamp, rsp.removed_stamp);
						mismatch_count++;
					end
				end
			end
			if (req_valid && !req_stall) begin
				expected_rsp_q.push_back(serve_request(req));
			end
		end
		awaiting_count = expected_rsp_q.size();
	end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the two-class selective-dequeue queue. The
// checker beside the block does all prediction and comparison; this module
// only drives requests, throttles responses and decides pass or fail.
module tb_top;

	import tcfsd_pkg::*;

	localparam int DEPTH        = 16;
	localparam int STAMP_WIDTH  = 16;
	localparam int RANDOM_ITEMS = 1450;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	req_item_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_item_t rsp;

	int mismatch_count;
	int awaiting_count;

	// Random-phase controls. The append share swings between fill, drain
	// and balanced phases so that the queue visits empty, full and every
	// occupancy in between.
	int append_pct;
	int phase_left;

	// Receiver throttle state. Both start at zero, so the first falling
	// edge picks a fresh pattern and drives the stall input.
	int stall_mode;
	int stall_left;

	two_class_fifo_selective_dequeue_unit #(
		.DEPTH       (DEPTH),
		.STAMP_WIDTH (STAMP_WIDTH)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	tcfsd_response_checker #(
		.DEPTH       (DEPTH),
		.STAMP_WIDTH (STAMP_WIDTH)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.req            (req),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.rsp            (rsp),
		.mismatch_count (mismatch_count),
		.awaiting_count (awaiting_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

	// The receiver switches among its own throttle patterns: no stall at
	// all, heavy random stall, light random stall, and long solid stalls.
	// Each pattern lasts a random stretch, so stalls land on appends, on
	// short and long scans, and on back-to-back responses alike.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(8, 40);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: begin
				rsp_stall <= 1'b0;
			end
			1: begin
				rsp_stall <= ($urandom_range(0, 1) == 1);
			end
			2: begin
				rsp_stall <= ($urandom_range(0, 3) == 0);
			end
			default: begin
				rsp_stall <= ((stall_left % 12) < 8);
			end
		endcase
	end

	// Presents one item from a falling edge and holds it, unchanged, until
	// a rising edge sees it taken. Returns at the following falling edge,
	// with valid still high so a burst can continue without a bubble.
	task automatic send_request(input op_t op, input logic cls,
			input logic [ITEM_STAMP_W-1:0] stamp);
		req_item_t item;
		item.operation   = op;
		item.entry_class = cls;
		item.entry_stamp = stamp;
		req       <= item;
		req_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (req_stall);
		@(negedge clk);
	endtask

	// Builds one random request under the current phase bias. Removals
	// carry random class and stamp bits too, since the block must ignore
	// them.
	task automatic send_random_request();
		op_t                     op;
		logic [ITEM_STAMP_W-1:0] stamp;
		if (phase_left == 0) begin
			case ($urandom_range(0, 2))
				0: append_pct = 80;
				1: append_pct = 25;
				default: append_pct = 50;
			endcase
			phase_left = $urandom_range(20, 60);
		end else begin
			phase_left--;
		end
		if ($urandom_range(0, 99) < append_pct) begin
			op = OP_APPEND;
		end else begin
			case ($urandom_range(0, 2))
				0: op = OP_ANY;
				1: op = OP_CLASS0;
				default: op = OP_CLASS1;
			endcase
		end
		case ($urandom_range(0, 9))
			0: stamp = '0;
			1: stamp = '1;
			default: stamp = ITEM_STAMP_W'($urandom_range(0, 65535));
		endcase
		send_request(op, 1'($urandom_range(0, 1)), stamp);
	endtask

	initial begin
		int sent;
		int burst_len;
		arst_n     = 1'b0;
		req_valid  = 1'b0;
		req        = '0;
		append_pct = 50;
		phase_left = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Removals of every kind on an empty queue must all report none.
		send_request(OP_ANY, 1'b1, 16'hFFFF);
		send_request(OP_CLASS0, 1'b0, 16'h0000);
		send_request(OP_CLASS1, 1'b1, 16'hA5A5);

		// With only a cat queued, asking for a dog misses; asking for a cat hits.
		send_request(OP_APPEND, 1'b1, 16'hFFFF);
		send_request(OP_CLASS0, 1'b1, 16'h1234);
		send_request(OP_CLASS1, 1'b0, 16'h0000);

		// Fill the queue to the brim with alternating classes and stamps at
		// both extremes, then try one append too many.
		send_request(OP_APPEND, 1'b0, 16'h0000);
		send_request(OP_APPEND, 1'b1, 16'hFFFF);
		for (int i = 2; i < DEPTH; i++) begin
			send_request(OP_APPEND, 1'(i % 2), ITEM_STAMP_W'(16'h1111 * i ^ 16'h5A5A));
		end
		send_request(OP_APPEND, 1'b1, 16'h8001);

		// On a full queue, take a cat out from behind the head, then the head.
		send_request(OP_CLASS1, 1'b0, 16'hFFFF);
		send_request(OP_ANY, 1'b1, 16'h0000);

		// Random part: bursts of back-to-back items separated by random gaps,
		// with some bursts running straight into the next.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst_len = $urandom_range(1, 12);
			for (int i = 0; i < burst_len && sent < RANDOM_ITEMS; i++) begin
				send_random_request();
				sent++;
			end
			if ($urandom_range(0, 3) != 0) begin
				req_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
		end
		req_valid <= 1'b0;

		// Drain every outstanding response, then keep the clock running in case
		// the block produces anything it should not.
		while (awaiting_count != 0) begin
			@(negedge clk);
		end
		repeat (40) @(negedge clk);

		if (mismatch_count == 0 && awaiting_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

[filelist.f]
hdl/tcfsd_pkg.sv
hdl/tcfsd_ctrl.sv
hdl/tcfsd_datapath.sv
hdl/two_class_fifo_selective_dequeue_unit.sv
tb/tcfsd_checker.sv
tb/tb_top.sv
